### src/jsm_pkg.sv
package jsm_pkg;

    localparam int AngleW = 8;
    localparam int AdcW   = 10;
    localparam int IntW   = 11;
    localparam int ProdW  = 20;
    localparam int Divisor = 511;

    localparam logic [1:0] MODE_SELECT = 2'd0;
    localparam logic [1:0] MODE_VERT   = 2'd1;
    localparam logic [1:0] MODE_HORIZ  = 2'd2;

    localparam logic [1:0] MENU_VERT  = 2'd0;
    localparam logic [1:0] MENU_HORIZ = 2'd1;
    localparam logic [1:0] MENU_EXIT  = 2'd2;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_CLICK = 2'd1;
    localparam logic [1:0] EV_LONG  = 2'd2;

    localparam logic [2:0] REG_REST_LEVEL  = 3'd0;
    localparam logic [2:0] REG_DEAD_ZONE   = 3'd1;
    localparam logic [2:0] REG_REPEAT_FAST = 3'd2;
    localparam logic [2:0] REG_REPEAT_SLOW = 3'd3;
    localparam logic [2:0] REG_LONG_PRESS  = 3'd4;
    localparam logic [2:0] REG_DEBOUNCE    = 3'd5;
    localparam logic [2:0] REG_ANGLE_MIN   = 3'd6;
    localparam logic [2:0] REG_ANGLE_MAX   = 3'd7;

    localparam logic [AngleW-1:0] ANGLE_RESET = 8'd90;

    typedef struct packed {
        logic [9:0]  rest_level;
        logic [8:0]  dead_zone;
        logic [9:0]  repeat_fast_ms;
        logic [9:0]  repeat_slow_ms;
        logic [13:0] long_press_ms;
        logic [9:0]  debounce_ms;
        logic [7:0]  angle_min;
        logic [7:0]  angle_max;
    } t_cfg;

    typedef struct packed {
        logic pos;
        logic neg;
    } t_dir;

    // truncating signed divide by 511: shift estimate plus a two-step correction
    function automatic logic signed [IntW-1:0] div511(input logic signed [ProdW-1:0] p);
        logic [ProdW-2:0] a;
        logic [9:0]       q0;
        logic [10:0]      r;
        logic [9:0]       q;
        begin
            a  = p[ProdW-1] ? (ProdW-1)'(-p) : p[ProdW-2:0];
            q0 = a[ProdW-2:9];
            r  = {2'b00, a[8:0]} + {1'b0, q0};
            if (r >= 11'(2 * Divisor)) begin
                q = q0 + 10'd2;
            end else if (r >= 11'(Divisor)) begin
                q = q0 + 10'd1;
            end else begin
                q = q0;
            end
            div511 = p[ProdW-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        end
    endfunction

    function automatic logic [IntW-1:0] interval_of(input logic [9:0] slow,
                                                    input logic signed [ProdW-1:0] p);
        logic signed [IntW:0] s;
        begin
            s = $signed({2'b00, slow}) + (IntW+1)'(div511(p));
            interval_of = s[IntW] ? '0 : s[IntW-1:0];
        end
    endfunction

    function automatic logic [AngleW-1:0] clamp_step(input logic [AngleW-1:0] ang,
                                                     input t_dir d,
                                                     input logic [AngleW-1:0] lo,
                                                     input logic [AngleW-1:0] hi);
        logic signed [9:0] a;
        begin
            a = $signed({2'b00, ang});
            if (d.pos) begin
                a = a + 10'sd1;
            end else if (d.neg) begin
                a = a - 10'sd1;
            end
            if (a < $signed({2'b00, lo})) begin
                a = $signed({2'b00, lo});
            end
            if (a > $signed({2'b00, hi})) begin
                a = $signed({2'b00, hi});
            end
            clamp_step = a[AngleW-1:0];
        end
    endfunction

endpackage

### src/jsm_axis.sv
module jsm_axis
    import jsm_pkg::*;
(
    input  logic [AdcW-1:0]         i_reading,
    input  t_cfg                    i_cfg,
    output t_dir                    o_dir,
    output logic signed [ProdW-1:0] o_prod
);

    logic signed [10:0] delta;
    logic signed [10:0] dz;
    logic signed [10:0] diff;
    logic [10:0]        mag_full;
    logic [8:0]         mag;
    logic signed [20:0] prod_full;

    always_comb begin
        delta = $signed({1'b0, i_reading}) - $signed({1'b0, i_cfg.rest_level});
        dz    = $signed({2'b00, i_cfg.dead_zone});
        o_dir.pos = delta > dz;
        o_dir.neg = delta < -dz;
        mag_full  = delta[10] ? 11'(-delta) : delta;
        // magnitude saturates at full scale
        mag  = (mag_full > 11'(Divisor)) ? 9'(Divisor) : mag_full[8:0];
        if (!(o_dir.pos || o_dir.neg)) begin
            mag = '0;
        end
        diff      = $signed({1'b0, i_cfg.repeat_fast_ms}) - $signed({1'b0, i_cfg.repeat_slow_ms});
        prod_full = $signed({12'b0, mag}) * $signed({{10{diff[10]}}, diff});
        o_prod    = prod_full[ProdW-1:0];
    end

endmodule

### src/jsm_button.sv
module jsm_button
    import jsm_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [TIME_BITS-1:0] i_now,
    input  logic                 i_raw,
    input  t_cfg                 i_cfg,
    output logic [1:0]           o_event
);

    logic                 r_raw_prev, n_raw_prev;
    logic                 r_stable, n_stable;
    logic                 r_long, n_long;
    logic [TIME_BITS-1:0] r_change, n_change;
    logic [TIME_BITS-1:0] r_press, n_press;

    logic                 chg;
    logic                 flip;
    logic                 pressed_now;
    logic                 held;
    logic [TIME_BITS-1:0] el_change;
    logic [TIME_BITS-1:0] el_press;

    always_comb begin
        chg       = i_raw != r_raw_prev;
        el_change = i_now - r_change;
        el_press  = i_now - r_press;
        // a fresh edge restarts the debounce window at zero elapsed time
        flip      = !chg && (el_change > TIME_BITS'(i_cfg.debounce_ms)) && (i_raw != r_stable);
        pressed_now = flip && !i_raw;

        n_raw_prev = i_raw;
        n_change   = chg ? i_now : r_change;
        n_stable   = flip ? i_raw : r_stable;
        n_press    = pressed_now ? i_now : r_press;
        n_long     = pressed_now ? 1'b0 : r_long;
        o_event    = EV_NONE;
        held       = 1'b0;

        if (flip && i_raw && !r_long) begin
            o_event = EV_CLICK;
        end else begin
            held = pressed_now ? (i_cfg.long_press_ms == '0)
                               : (el_press >= TIME_BITS'(i_cfg.long_press_ms));
            if (!n_stable && !n_long && held) begin
                n_long  = 1'b1;
                o_event = EV_LONG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_prev <= 1'b1;
            r_stable   <= 1'b1;
            r_long     <= 1'b0;
            r_change   <= '0;
            r_press    <= '0;
        end else if (i_step) begin
            r_raw_prev <= n_raw_prev;
            r_stable   <= n_stable;
            r_long     <= n_long;
            r_change   <= n_change;
            r_press    <= n_press;
        end
    end

endmodule

### src/joystick_servo_menu_controller.sv
// pipeline: a sample beat accepted into the input register passes the deflection
// multiply and interval divide registers, then the state update loads the result
// register
// throughput: one sample per cycle unless i_out_ready stalls the output; the state update is combinational
// synchronous active-low reset loads the default configuration and the
// idle menu state; no memory, so no clearing pass
module joystick_servo_menu_controller
    import jsm_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [13:0]          i_cfg_data,

    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [TIME_BITS-1:0] i_now_ms,
    input  logic [AdcW-1:0]      i_stick_x,
    input  logic [AdcW-1:0]      i_stick_y,
    input  logic                 i_button_level,

    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_current_mode,
    output logic [1:0]           o_menu_item,
    output logic [AngleW-1:0]    o_vertical_angle,
    output logic [AngleW-1:0]    o_horizontal_angle,
    output logic [1:0]           o_press_event,
    output logic                 o_redraw
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rest_level     <= 10'd512;
            r_cfg.dead_zone      <= 9'd120;
            r_cfg.repeat_fast_ms <= 10'd50;
            r_cfg.repeat_slow_ms <= 10'd220;
            r_cfg.long_press_ms  <= 14'd800;
            r_cfg.debounce_ms    <= 10'd40;
            r_cfg.angle_min      <= 8'd0;
            r_cfg.angle_max      <= 8'd180;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_REST_LEVEL:  r_cfg.rest_level     <= i_cfg_data[9:0];
                REG_DEAD_ZONE:   r_cfg.dead_zone      <= i_cfg_data[8:0];
                REG_REPEAT_FAST: r_cfg.repeat_fast_ms <= i_cfg_data[9:0];
                REG_REPEAT_SLOW: r_cfg.repeat_slow_ms <= i_cfg_data[9:0];
                REG_LONG_PRESS:  r_cfg.long_press_ms  <= i_cfg_data[13:0];
                REG_DEBOUNCE:    r_cfg.debounce_ms    <= i_cfg_data[9:0];
                REG_ANGLE_MIN:   r_cfg.angle_min      <= i_cfg_data[7:0];
                REG_ANGLE_MAX:   r_cfg.angle_max      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // pipeline valids and stall chain
    logic r_va, r_vb, r_vc, r_vo;
    logic out_free, c_move, c_free, b_move, b_free, a_move, a_free, in_take;

    always_comb begin
        out_free = !r_vo || i_out_ready;
        c_move   = r_vc && out_free;
        c_free   = !r_vc || c_move;
        b_move   = r_vb && c_free;
        b_free   = !r_vb || b_move;
        a_move   = r_va && b_free;
        a_free   = !r_va || a_move;
        in_take  = i_in_valid && a_free;
    end

    assign o_in_ready  = a_free;
    assign o_out_valid = r_vo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (a_free) begin
                r_va <= i_in_valid;
            end
            if (b_free) begin
                r_vb <= r_va;
            end
            if (c_free) begin
                r_vc <= r_vb;
            end
            if (out_free) begin
                r_vo <= r_vc;
            end
        end
    end

    // input register
    logic [TIME_BITS-1:0] r_a_now;
    logic [AdcW-1:0]      r_a_x, r_a_y;
    logic                 r_a_raw;

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_now <= i_now_ms;
            r_a_x   <= i_stick_x;
            r_a_y   <= i_stick_y;
            r_a_raw <= i_button_level;
        end
    end

    // deflection and slope product
    t_dir                    a_dir_x, a_dir_y;
    logic signed [ProdW-1:0] a_prod_x, a_prod_y;

    jsm_axis u_axis_x (
        .i_reading (r_a_x),
        .i_cfg     (r_cfg),
        .o_dir     (a_dir_x),
        .o_prod    (a_prod_x)
    );

    jsm_axis u_axis_y (
        .i_reading (r_a_y),
        .i_cfg     (r_cfg),
        .o_dir     (a_dir_y),
        .o_prod    (a_prod_y)
    );

    logic [TIME_BITS-1:0]    r_b_now;
    logic                    r_b_raw;
    t_dir                    r_b_dir_x, r_b_dir_y;
    logic signed [ProdW-1:0] r_b_prod_x, r_b_prod_y;

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b_now    <= r_a_now;
            r_b_raw    <= r_a_raw;
            r_b_dir_x  <= a_dir_x;
            r_b_dir_y  <= a_dir_y;
            r_b_prod_x <= a_prod_x;
            r_b_prod_y <= a_prod_y;
        end
    end

    // repeat intervals
    logic [TIME_BITS-1:0] r_c_now;
    logic                 r_c_raw;
    t_dir                 r_c_dir_x, r_c_dir_y;
    logic [IntW-1:0]      r_c_int_x, r_c_int_y;

    always_ff @(posedge i_clk) begin
        if (b_move) begin
            r_c_now   <= r_b_now;
            r_c_raw   <= r_b_raw;
            r_c_dir_x <= r_b_dir_x;
            r_c_dir_y <= r_b_dir_y;
            r_c_int_x <= interval_of(r_cfg.repeat_slow_ms, r_b_prod_x);
            r_c_int_y <= interval_of(r_cfg.repeat_slow_ms, r_b_prod_y);
        end
    end

    // state update
    logic [1:0] ev;

    jsm_button #(
        .TIME_BITS (TIME_BITS)
    ) u_button (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (c_move),
        .i_now   (r_c_now),
        .i_raw   (r_c_raw),
        .i_cfg   (r_cfg),
        .o_event (ev)
    );

    logic [1:0]           r_mode, n_mode;
    logic [1:0]           r_menu, n_menu;
    logic [AngleW-1:0]    r_vert, n_vert;
    logic [AngleW-1:0]    r_horiz, n_horiz;
    logic [TIME_BITS-1:0] r_last, n_last;
    logic [TIME_BITS-1:0] el_last;
    logic                 ge_x, ge_y, last_upd, ok, redraw, done;

    always_comb begin
        el_last  = r_c_now - r_last;
        ge_x     = el_last >= TIME_BITS'(r_c_int_x);
        ge_y     = el_last >= TIME_BITS'(r_c_int_y);
        n_mode   = r_mode;
        n_menu   = r_menu;
        n_vert   = r_vert;
        n_horiz  = r_horiz;
        last_upd = 1'b0;
        redraw   = 1'b0;
        done     = 1'b0;
        ok       = 1'b0;

        if (n_mode == MODE_SELECT) begin
            ok = ge_y;
            if ((r_c_dir_y.pos || r_c_dir_y.neg) && ok) begin
                last_upd = 1'b1;
                if (r_c_dir_y.pos) begin
                    if (n_menu != MENU_VERT) begin
                        n_menu = n_menu - 2'd1;
                    end
                end else if (n_menu != MENU_EXIT) begin
                    n_menu = n_menu + 2'd1;
                end
                redraw = 1'b1;
            end
            if (ev == EV_CLICK) begin
                case (n_menu)
                    MENU_VERT:  n_mode = MODE_VERT;
                    MENU_HORIZ: n_mode = MODE_HORIZ;
                    default:    n_menu = MENU_VERT;
                endcase
                redraw = 1'b1;
            end
        end

        if (n_mode == MODE_VERT) begin
            if (ev == EV_LONG) begin
                n_mode = MODE_SELECT;
                redraw = 1'b1;
                done   = 1'b1;
            end else begin
                // once the repeat time moved to now, only a zero interval passes
                ok = last_upd ? (r_c_int_y == '0) : ge_y;
                if ((r_c_dir_y.pos || r_c_dir_y.neg) && ok) begin
                    last_upd = 1'b1;
                    n_vert   = clamp_step(n_vert, r_c_dir_y, r_cfg.angle_min, r_cfg.angle_max);
                    redraw   = 1'b1;
                end
            end
        end

        if (!done && n_mode == MODE_HORIZ) begin
            if (ev == EV_LONG) begin
                n_mode = MODE_SELECT;
                redraw = 1'b1;
            end else begin
                ok = last_upd ? (r_c_int_x == '0) : ge_x;
                if ((r_c_dir_x.pos || r_c_dir_x.neg) && ok) begin
                    last_upd = 1'b1;
                    n_horiz  = clamp_step(n_horiz, r_c_dir_x, r_cfg.angle_min, r_cfg.angle_max);
                    redraw   = 1'b1;
                end
            end
        end

        n_last = last_upd ? r_c_now : r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_SELECT;
            r_menu  <= MENU_VERT;
            r_vert  <= ANGLE_RESET;
            r_horiz <= ANGLE_RESET;
            r_last  <= '0;
        end else if (c_move) begin
            r_mode  <= n_mode;
            r_menu  <= n_menu;
            r_vert  <= n_vert;
            r_horiz <= n_horiz;
            r_last  <= n_last;
        end
    end

    // result register
    logic [1:0]        r_o_mode, r_o_menu, r_o_event;
    logic [AngleW-1:0] r_o_vert, r_o_horiz;
    logic              r_o_redraw;

    always_ff @(posedge i_clk) begin
        if (c_move) begin
            r_o_mode   <= n_mode;
            r_o_menu   <= n_menu;
            r_o_vert   <= n_vert;
            r_o_horiz  <= n_horiz;
            r_o_event  <= ev;
            r_o_redraw <= redraw;
        end
    end

    assign o_current_mode     = r_o_mode;
    assign o_menu_item        = r_o_menu;
    assign o_vertical_angle   = r_o_vert;
    assign o_horizontal_angle = r_o_horiz;
    assign o_press_event      = r_o_event;
    assign o_redraw           = r_o_redraw;

endmodule

### verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import jsm_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PLAN_LEN     = 28;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 100;
    localparam int SETTLE_LEN   = 8;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] item;
        logic [7:0] vdeg;
        logic [7:0] hdeg;
        logic [1:0] ev;
        logic       rd;
    } t_panel;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [9:0]  sx;
        logic [9:0]  sy;
        logic        btn;
        logic        typed;
        t_panel      want;
    } t_plan_row;

    localparam t_panel NO_CHECK = '0;

    localparam t_cfg CFG_DEFAULT = '{10'd512, 9'd120, 10'd50, 10'd220, 14'd800, 10'd40,
                                     8'd0, 8'd180};
    localparam t_cfg CFG_ALL_LOW  = '{10'd0, 9'd0, 10'd0, 10'd0, 14'd0, 10'd0, 8'd0, 8'd0};
    localparam t_cfg CFG_ALL_HIGH = '{10'd1023, 9'd511, 10'd1000, 10'd1000, 14'd10000,
                                      10'd1000, 8'd180, 8'd180};
    // fast at zero and slow at 1000, and a min above the max
    localparam t_cfg CFG_CROSSED  = '{10'd512, 9'd60, 10'd0, 10'd1000, 14'd300, 10'd10,
                                      8'd150, 8'd30};

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [13:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] now_in = '0;
    logic [9:0]  sx_in = 10'd512;
    logic [9:0]  sy_in = 10'd512;
    logic        btn_in = 1'b1;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  mode_out;
    logic [1:0]  item_out;
    logic [7:0]  vdeg_out;
    logic [7:0]  hdeg_out;
    logic [1:0]  ev_out;
    logic        rd_out;

    joystick_servo_menu_controller dut (
        .i_clk             (i_clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_now_ms          (now_in),
        .i_stick_x         (sx_in),
        .i_stick_y         (sy_in),
        .i_button_level    (btn_in),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_current_mode    (mode_out),
        .o_menu_item       (item_out),
        .o_vertical_angle  (vdeg_out),
        .o_horizontal_angle(hdeg_out),
        .o_press_event     (ev_out),
        .o_redraw          (rd_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // panel state mirror
    t_cfg        cfg_now;
    logic [1:0]  pan_mode;
    logic [1:0]  pan_item;
    int          vert_deg;
    int          horiz_deg;
    logic [31:0] last_rep_ms;
    logic [31:0] btn_edge_ms;
    logic [31:0] btn_down_ms;
    logic        btn_prev;
    logic        btn_stable;
    logic        long_fired;

    t_panel panel_q[$];
    int     fails = 0;
    int     cycle_count = 0;
    bit     idling_on = 1'b1;
    int     stall_left = 0;

    // button and clock of the random part
    logic [31:0] now_ms;
    logic [31:0] seg_start;
    logic [31:0] seg_len;
    logic        btn_held;
    int          scale;
    t_cfg        phase_cfg;

    t_plan_row plan [PLAN_LEN] = '{
        '{32'd0,    10'd512, 10'd512,  1'b1, 1'b1,
          '{MODE_SELECT, MENU_VERT, 8'd90, 8'd90, EV_NONE, 1'b0}},
        '{32'd100,  10'd512, 10'd0,    1'b1, 1'b1,
          '{MODE_SELECT, MENU_HORIZ, 8'd90, 8'd90, EV_NONE, 1'b1}},
        '{32'd120,  10'd512, 10'd0,    1'b1, 1'b1,
          '{MODE_SELECT, MENU_HORIZ, 8'd90, 8'd90, EV_NONE, 1'b0}},
        '{32'd200,  10'd512, 10'd0,    1'b1, 1'b1,
          '{MODE_SELECT, MENU_EXIT, 8'd90, 8'd90, EV_NONE, 1'b1}},
        '{32'd300,  10'd512, 10'd0,    1'b1, 1'b1,
          '{MODE_SELECT, MENU_EXIT, 8'd90, 8'd90, EV_NONE, 1'b1}},
        '{32'd1000, 10'd512, 10'd512,  1'b0, 1'b0, NO_CHECK},
        '{32'd1041, 10'd512, 10'd512,  1'b0, 1'b0, NO_CHECK},
        '{32'd1100, 10'd512, 10'd512,  1'b1, 1'b0, NO_CHECK},
        '{32'd1141, 10'd512, 10'd512,  1'b1, 1'b1,
          '{MODE_SELECT, MENU_VERT, 8'd90, 8'd90, EV_CLICK, 1'b1}},
        '{32'd1200, 10'd512, 10'd512,  1'b0, 1'b0, NO_CHECK},
        '{32'd1250, 10'd512, 10'd512,  1'b0, 1'b0, NO_CHECK},
        '{32'd1300, 10'd512, 10'd512,  1'b1, 1'b0, NO_CHECK},
        '{32'd1350, 10'd512, 10'd1023, 1'b1, 1'b0, NO_CHECK},
        '{32'd1400, 10'd512, 10'd1023, 1'b1, 1'b0, NO_CHECK},
        '{32'd1500, 10'd1023, 10'd600, 1'b1, 1'b0, NO_CHECK},
        '{32'd1600, 10'd512, 10'd633,  1'b1, 1'b0, NO_CHECK},
        '{32'd2000, 10'd512, 10'd512,  1'b0, 1'b0, NO_CHECK},
        '{32'd2050, 10'd512, 10'd512,  1'b0, 1'b0, NO_CHECK},
        '{32'd2850, 10'd512, 10'd1023, 1'b0, 1'b0, NO_CHECK},
        '{32'd2950, 10'd512, 10'd512,  1'b1, 1'b0, NO_CHECK},
        '{32'd3000, 10'd512, 10'd512,  1'b1, 1'b0, NO_CHECK},
        '{32'd3100, 10'd512, 10'd0,    1'b1, 1'b0, NO_CHECK},
        '{32'd3200, 10'd512, 10'd512,  1'b0, 1'b0, NO_CHECK},
        '{32'd3250, 10'd512, 10'd512,  1'b0, 1'b0, NO_CHECK},
        '{32'd3300, 10'd512, 10'd512,  1'b1, 1'b0, NO_CHECK},
        '{32'd3350, 10'd0,   10'd512,  1'b1, 1'b0, NO_CHECK},
        '{32'hFFFF_FFFF, 10'd1023, 10'd1023, 1'b1, 1'b0, NO_CHECK},
        '{32'd48,   10'd1023, 10'd0,   1'b1, 1'b0, NO_CHECK}
    };

    task automatic panel_reset();
        cfg_now     = CFG_DEFAULT;
        pan_mode    = MODE_SELECT;
        pan_item    = MENU_VERT;
        vert_deg    = int'(ANGLE_RESET);
        horiz_deg   = int'(ANGLE_RESET);
        last_rep_ms = '0;
        btn_edge_ms = '0;
        btn_down_ms = '0;
        btn_prev    = 1'b1;
        btn_stable  = 1'b1;
        long_fired  = 1'b0;
    endtask

    function automatic logic [1:0] debounce_button(input logic [31:0] now, input logic raw);
        if (raw != btn_prev) begin
            btn_prev    = raw;
            btn_edge_ms = now;
        end
        if ((now - btn_edge_ms) > 32'(cfg_now.debounce_ms) && raw != btn_stable) begin
            btn_stable = raw;
            if (!btn_stable) begin
                btn_down_ms = now;
                long_fired  = 1'b0;
            end else if (!long_fired) begin
                return EV_CLICK;
            end
        end
        if (!btn_stable && !long_fired
                && (now - btn_down_ms) >= 32'(cfg_now.long_press_ms)) begin
            long_fired = 1'b1;
            return EV_LONG;
        end
        return EV_NONE;
    endfunction

    function automatic int stick_sense(input logic [9:0] rdg, output int mag);
        int delta;
        int dz;
        delta = int'(rdg) - int'(cfg_now.rest_level);
        dz    = int'(cfg_now.dead_zone);
        mag   = 0;
        if (delta > dz) begin
            mag = delta;
            return 1;
        end
        if (delta < -dz) begin
            mag = -delta;
            return -1;
        end
        return 0;
    endfunction

    function automatic logic [31:0] repeat_gap(input int mag);
        int m;
        int r;
        m = (mag > 511) ? 511 : mag;
        r = int'(cfg_now.repeat_slow_ms)
          + (m * (int'(cfg_now.repeat_fast_ms) - int'(cfg_now.repeat_slow_ms))) / 511;
        return (r < 0) ? 32'd0 : 32'(r);
    endfunction

    function automatic bit repeat_due(input logic [31:0] now, input logic [31:0] gap);
        if ((now - last_rep_ms) >= gap) begin
            last_rep_ms = now;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int angle_move(input int a, input int d);
        int v;
        v = a + d;
        if (v < int'(cfg_now.angle_min)) v = int'(cfg_now.angle_min);
        if (v > int'(cfg_now.angle_max)) v = int'(cfg_now.angle_max);
        return v;
    endfunction

    // the three mode blocks run in order, so a click into an axis mode is serviced at once
    function automatic t_panel panel_after(input logic [31:0] now, input logic [9:0] sx,
                                           input logic [9:0] sy, input logic btn);
        logic [1:0] ev;
        logic       rd;
        bit         done;
        int         mag;
        int         d;
        t_panel     r;
        ev   = debounce_button(now, btn);
        rd   = 1'b0;
        done = 1'b0;
        if (pan_mode == MODE_SELECT) begin
            d = stick_sense(sy, mag);
            if (d != 0 && repeat_due(now, repeat_gap(mag))) begin
                if (d > 0) begin
                    if (pan_item != MENU_VERT) pan_item = pan_item - 2'd1;
                end else if (pan_item != MENU_EXIT) begin
                    pan_item = pan_item + 2'd1;
                end
                rd = 1'b1;
            end
            if (ev == EV_CLICK) begin
                if (pan_item == MENU_VERT) pan_mode = MODE_VERT;
                else if (pan_item == MENU_HORIZ) pan_mode = MODE_HORIZ;
                else pan_item = MENU_VERT;
                rd = 1'b1;
            end
        end
        if (pan_mode == MODE_VERT) begin
            if (ev == EV_LONG) begin
                pan_mode = MODE_SELECT;
                rd       = 1'b1;
                done     = 1'b1;
            end else begin
                d = stick_sense(sy, mag);
                if (d != 0 && repeat_due(now, repeat_gap(mag))) begin
                    vert_deg = angle_move(vert_deg, d);
                    rd       = 1'b1;
                end
            end
        end
        if (!done && pan_mode == MODE_HORIZ) begin
            if (ev == EV_LONG) begin
                pan_mode = MODE_SELECT;
                rd       = 1'b1;
            end else begin
                d = stick_sense(sx, mag);
                if (d != 0 && repeat_due(now, repeat_gap(mag))) begin
                    horiz_deg = angle_move(horiz_deg, d);
                    rd        = 1'b1;
                end
            end
        end
        r.mode = pan_mode;
        r.item = pan_item;
        r.vdeg = vert_deg[7:0];
        r.hdeg = horiz_deg[7:0];
        r.ev   = ev;
        r.rd   = rd;
        return r;
    endfunction

    // called just after a rising edge; returns just after the accepting edge
    task automatic offer_sample(input logic [31:0] now, input logic [9:0] sx,
                                input logic [9:0] sy, input logic btn,
                                input logic typed, input t_panel want);
        t_panel pred;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        now_in   <= now;
        sx_in    <= sx;
        sy_in    <= sy;
        btn_in   <= btn;
        @(posedge i_clk);
        while (in_ready !== 1'b1) @(posedge i_clk);
        pred = panel_after(now, sx, sy, btn);
        panel_q.push_back(typed ? want : pred);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (panel_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_LEN) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [13:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input t_cfg c);
        write_reg(REG_REST_LEVEL,  14'(c.rest_level));
        write_reg(REG_DEAD_ZONE,   14'(c.dead_zone));
        write_reg(REG_REPEAT_FAST, 14'(c.repeat_fast_ms));
        write_reg(REG_REPEAT_SLOW, 14'(c.repeat_slow_ms));
        write_reg(REG_LONG_PRESS,  c.long_press_ms);
        write_reg(REG_DEBOUNCE,    14'(c.debounce_ms));
        write_reg(REG_ANGLE_MIN,   14'(c.angle_min));
        write_reg(REG_ANGLE_MAX,   14'(c.angle_max));
        cfg_we  <= 1'b0;
        cfg_now = c;
    endtask

    function automatic t_cfg random_settings();
        t_cfg c;
        c.rest_level     = 10'($urandom_range(0, 1023));
        c.dead_zone      = 9'($urandom_range(0, 511) >> $urandom_range(0, 2));
        c.repeat_fast_ms = 10'($urandom_range(0, 1000));
        c.repeat_slow_ms = 10'($urandom_range(0, 1000));
        c.long_press_ms  = 14'($urandom_range(0, 3000));
        c.debounce_ms    = 10'($urandom_range(0, 200));
        c.angle_min      = 8'($urandom_range(0, 180));
        c.angle_max      = 8'($urandom_range(0, 180));
        return c;
    endfunction

    // mostly near the dead zone edge, the rails or the rest point
    function automatic logic [9:0] pick_axis();
        int c;
        int dz;
        int v;
        c  = int'(cfg_now.rest_level);
        dz = int'(cfg_now.dead_zone);
        case ($urandom_range(0, 9))
            0, 1:    v = c + $urandom_range(0, 2 * dz) - dz;
            2:       v = c + dz + 1;
            3:       v = c - dz - 1;
            4:       v = 0;
            5:       v = 1023;
            default: v = $urandom_range(0, 1023);
        endcase
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return 10'(v);
    endfunction

    function automatic logic [31:0] time_step();
        int r;
        r = $urandom_range(0, 49);
        if (r == 0) return $urandom;
        if (r < 5) return 32'($urandom_range(0, 4 * scale));
        if (r < 25) return 32'($urandom_range(0, scale));
        return 32'($urandom_range(0, scale / 4 + 1));
    endfunction

    always @(posedge i_clk) begin
        if (stall_left == 0 && idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 3);
        end
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : result_mon
        t_panel want;
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            if (panel_q.size() == 0) begin
                $error("result beat with nothing pending");
                fails++;
            end else begin
                want = panel_q.pop_front();
                check_field("current_mode",     32'(want.mode), 32'(mode_out));
                check_field("menu_item",        32'(want.item), 32'(item_out));
                check_field("vertical_angle",   32'(want.vdeg), 32'(vdeg_out));
                check_field("horizontal_angle", 32'(want.hdeg), 32'(hdeg_out));
                check_field("press_event",      32'(want.ev),   32'(ev_out));
                check_field("redraw",           32'(want.rd),   32'(rd_out));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("joystick_servo_menu_controller verification failed");
            $finish;
        end
    end

    initial begin
        panel_reset();
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < PLAN_LEN; i++) begin
            offer_sample(plan[i].now_ms, plan[i].sx, plan[i].sy, plan[i].btn,
                         plan[i].typed, plan[i].want);
        end

        now_ms    = 32'd5000;
        seg_start = now_ms;
        seg_len   = '0;
        btn_held  = 1'b1;
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                1:       phase_cfg = CFG_ALL_LOW;
                2:       phase_cfg = CFG_ALL_HIGH;
                3:       phase_cfg = CFG_CROSSED;
                default: phase_cfg = random_settings();
            endcase
            load_settings(phase_cfg);
            if (ph == PHASES - 1) idling_on = 1'b0;
            scale = (int'(cfg_now.long_press_ms) + int'(cfg_now.debounce_ms)) / 8 + 20;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                logic btn;
                now_ms = now_ms + time_step();
                // press and release runs of random length, short clicks and long holds
                if ((now_ms - seg_start) >= seg_len) begin
                    btn_held  = ~btn_held;
                    seg_start = now_ms;
                    if (!btn_held) begin
                        seg_len = $urandom_range(0, 2 * int'(cfg_now.long_press_ms)
                                                 + int'(cfg_now.debounce_ms) + 50);
                    end else begin
                        seg_len = $urandom_range(0, 3 * int'(cfg_now.debounce_ms) + 300);
                    end
                end
                btn = ($urandom_range(0, 19) == 0) ? ~btn_held : btn_held;
                offer_sample(now_ms, pick_axis(), pick_axis(), btn, 1'b0, NO_CHECK);
            end
        end

        settle();
        if (fails == 0) begin
            $display("joystick_servo_menu_controller verification clean");
        end else begin
            $display("joystick_servo_menu_controller verification failed");
        end
        $finish;
    end

endmodule
